FILE: rtl/mvm_pkg.sv
package mvm_pkg;

  localparam int DIM_DEF = 4;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int DOT_W  = 34;
  localparam int IDX_W  = 2;

  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // write request broadcast to every cell
  typedef struct packed {
    logic                    mat_en;
    logic                    vec_en;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } mvm_wr_t;

  // row token that travels down the chain next to its partial sum
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic             last;
  } mvm_tok_t;

endpackage

FILE: rtl/mvm_cell.sv
module mvm_cell #(
  parameter int DIM = mvm_pkg::DIM_DEF,
  parameter int K   = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  mvm_pkg::mvm_wr_t                 wr,
  input  mvm_pkg::mvm_tok_t                tok_in,
  input  logic signed [mvm_pkg::DOT_W-1:0] sum_in,
  output mvm_pkg::mvm_tok_t                tok_out,
  output logic signed [mvm_pkg::DOT_W-1:0] sum_out
);
  import mvm_pkg::*;

  localparam int ROW_W = $clog2(DIM);

  // column K of the matrix and element K of the vector
  logic signed [VAL_W-1:0] col_r [DIM];
  logic signed [VAL_W-1:0] vec_r;
  logic [ROW_W-1:0]        ptr_r, ptr_nxt;
  logic                    tok_vld_r;
  logic [IDX_W-1:0]        tok_row_r;
  logic                    tok_last_r;
  logic signed [DOT_W-1:0] sum_r;

  logic                    col_hit, row_ok;
  logic signed [PROD_W-1:0] prod;

  assign col_hit = (int'(wr.col) == K);
  assign row_ok  = (int'(wr.row) < DIM);

  always_ff @(posedge clk) begin
    if (wr.mat_en && col_hit && row_ok) begin
      col_r[ROW_W'(wr.row)] <= wr.value;
    end
    if (wr.vec_en && col_hit) begin
      vec_r <= wr.value;
    end
  end

  // tokens arrive in row order, so a local pointer tracks the row
  always_comb begin
    ptr_nxt = ptr_r;
    if (adv && tok_in.valid) begin
      if (ptr_r == ROW_W'(DIM - 1)) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  assign prod = col_r[ptr_r] * vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      tok_vld_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (adv) begin
        tok_vld_r <= tok_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_row_r  <= tok_in.row;
      tok_last_r <= tok_in.last;
      sum_r      <= sum_in + {{(DOT_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign tok_out = '{valid: tok_vld_r, row: tok_row_r, last: tok_last_r};
  assign sum_out = sum_r;

endmodule

FILE: rtl/matrix_vector_multiply_top.sv
// Channel  Direction  Handshake          Payload
// in_      request    in_valid/in_stall  opcode, row/column index, element, start
// out_     result     out_valid/out_stall  result_row, dot_product, final_row
//
// Matrix writes and vector loads are taken whenever in_stall is low.
// A start request raises in_stall; the rows are then issued one by one, pass
// through every cell of the chain and are held in the output register.
// Output stall while a result is held freezes the whole chain; the input
// stays stalled until the final row result is taken. Reset (sync, active low)
// clears control only; matrix and vector stores hold garbage until written.
module matrix_vector_multiply_top #(
  parameter int DIM = mvm_pkg::DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [mvm_pkg::IDX_W-1:0]        in_row_index,
  input  logic [mvm_pkg::IDX_W-1:0]        in_column_index,
  input  logic signed [mvm_pkg::VAL_W-1:0] in_element_value,
  input  logic                             in_start_product,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mvm_pkg::IDX_W-1:0]        out_result_row,
  output logic signed [mvm_pkg::DOT_W-1:0] out_dot_product,
  output logic                             out_final_row
);
  import mvm_pkg::*;

  localparam int ROW_W = $clog2(DIM);

  logic             busy_r, busy_nxt;
  logic             issue_r, issue_nxt;
  logic [ROW_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_row_r;
  logic signed [DOT_W-1:0] out_dot_r;
  logic             out_last_r;

  logic    in_acc, out_acc, adv;
  mvm_wr_t wr;

  // chain taps: index k feeds cell k, index DIM is the chain output
  mvm_tok_t                tok [DIM+1];
  logic signed [DOT_W-1:0] sum [DIM+1];

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_acc  = out_valid_r && !out_stall;
  // chain moves whenever the output register can take a word
  assign adv      = !out_valid_r || !out_stall;

  assign wr.mat_en = in_acc && (in_opcode == OP_MATRIX);
  assign wr.vec_en = in_acc && (in_opcode == OP_VECTOR);
  assign wr.row    = in_row_index;
  assign wr.col    = in_column_index;
  assign wr.value  = in_element_value;

  // row issue: one token per cycle into the head of the chain while the chain moves
  always_comb begin
    busy_nxt  = busy_r;
    issue_nxt = issue_r;
    cnt_nxt   = cnt_r;
    if (in_acc && in_start_product) begin
      busy_nxt  = 1'b1;
      issue_nxt = 1'b1;
      cnt_nxt   = '0;
    end else if (issue_r && adv) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ROW_W'(DIM - 1)) begin
        issue_nxt = 1'b0;
      end
    end
    if (out_acc && out_last_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      issue_r <= issue_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign tok[0].valid = issue_r;
  assign tok[0].row   = IDX_W'(cnt_r);
  assign tok[0].last  = (cnt_r == ROW_W'(DIM - 1));
  assign sum[0]       = '0;

  // cell k adds matrix[row][k] * vector[k] to the passing sum
  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mvm_cell #(
      .DIM (DIM),
      .K   (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr      (wr),
      .tok_in  (tok[k]),
      .sum_in  (sum[k]),
      .tok_out (tok[k+1]),
      .sum_out (sum[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok[DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok[DIM].valid) begin
      out_row_r  <= tok[DIM].row;
      out_dot_r  <= sum[DIM];
      out_last_r <= tok[DIM].last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_row  = out_row_r;
  assign out_dot_product = out_dot_r;
  assign out_final_row   = out_last_r;

  // results only appear during a run
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result outside a run");

  // taking the final row reopens the input
  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_final_row) |=> !in_stall)
    else $error("input still stalled after final row");

  // a start request launches row issue
  a_start_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_start_product) |=> (tok[0].valid && cnt_r == '0))
    else $error("start did not launch row issue");

  // no issue in flight while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (!issue_r && !out_valid_r))
    else $error("activity while idle");

endmodule
